// File: design/isp_pkg.sv
package isp_pkg;

   localparam int CH_WIDTH       = 8;
   localparam int BASE_WIDTH     = 5;
   localparam int DIGIT_WIDTH    = 4;
   localparam int OUT_WIDTH      = 64;
   localparam int CONSUMED_WIDTH = 16;
   localparam int CLASS_WIDTH    = 3;

   // character codes
   localparam logic [CH_WIDTH-1:0] CH_SPACE = 8'h20;
   localparam logic [CH_WIDTH-1:0] CH_TAB   = 8'h09;
   localparam logic [CH_WIDTH-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CH_WIDTH-1:0] CH_MINUS = 8'h2D;
   localparam logic [CH_WIDTH-1:0] CH_ZERO  = 8'h30;
   localparam logic [CH_WIDTH-1:0] CH_NINE  = 8'h39;
   localparam logic [CH_WIDTH-1:0] CH_LO_A  = 8'h61;
   localparam logic [CH_WIDTH-1:0] CH_LO_F  = 8'h66;
   localparam logic [CH_WIDTH-1:0] CH_UP_A  = 8'h41;
   localparam logic [CH_WIDTH-1:0] CH_UP_F  = 8'h46;
   localparam logic [CH_WIDTH-1:0] CH_LO_X  = 8'h78;
   localparam logic [CH_WIDTH-1:0] CH_UP_X  = 8'h58;

   // radix constants
   localparam logic [BASE_WIDTH-1:0] BASE_AUTO = 5'd0;
   localparam logic [BASE_WIDTH-1:0] BASE_OCT  = 5'd8;
   localparam logic [BASE_WIDTH-1:0] BASE_DEC  = 5'd10;
   localparam logic [BASE_WIDTH-1:0] BASE_HEX  = 5'd16;

   // character classes
   localparam logic [CLASS_WIDTH-1:0] CLS_OTHER = 3'd0;
   localparam logic [CLASS_WIDTH-1:0] CLS_SPACE = 3'd1;
   localparam logic [CLASS_WIDTH-1:0] CLS_PLUS  = 3'd2;
   localparam logic [CLASS_WIDTH-1:0] CLS_MINUS = 3'd3;
   localparam logic [CLASS_WIDTH-1:0] CLS_ZERO  = 3'd4;
   localparam logic [CLASS_WIDTH-1:0] CLS_X     = 3'd5;

   typedef struct packed {
      logic [CH_WIDTH-1:0] ch;
      logic                start_req;
   } req_type;

   typedef struct packed {
      logic signed [OUT_WIDTH-1:0] value;
      logic [CONSUMED_WIDTH-1:0]   consumed;
   } rsp_type;

   typedef struct packed {
      logic                   start;
      logic [BASE_WIDTH-1:0]  base;
      logic [CLASS_WIDTH-1:0] cls;
      logic                   is_digit;
      logic [DIGIT_WIDTH-1:0] digit;
   } token_type;

endpackage

// File: design/isp_front.sv
module isp_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  isp_pkg::req_type                  req_payload,
   input  logic                              csr_we,
   input  logic [isp_pkg::BASE_WIDTH-1:0]    csr_wdata,
   output logic                              push,
   output isp_pkg::token_type                token,
   input  logic                              queue_full
);

   logic [isp_pkg::BASE_WIDTH-1:0] number_base_ff;
   logic [isp_pkg::BASE_WIDTH-1:0] number_base_in;
   logic [isp_pkg::CH_WIDTH-1:0]   ch;

   assign ch             = req_payload.ch;
   assign number_base_in = csr_we ? csr_wdata : number_base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         number_base_ff <= isp_pkg::BASE_AUTO;
      end else begin
         number_base_ff <= number_base_in;
      end
   end

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      token.start = req_payload.start_req;
      token.base  = number_base_ff;

      priority if (ch == isp_pkg::CH_SPACE || ch == isp_pkg::CH_TAB) begin
         token.cls = isp_pkg::CLS_SPACE;
      end else if (ch == isp_pkg::CH_PLUS) begin
         token.cls = isp_pkg::CLS_PLUS;
      end else if (ch == isp_pkg::CH_MINUS) begin
         token.cls = isp_pkg::CLS_MINUS;
      end else if (ch == isp_pkg::CH_ZERO) begin
         token.cls = isp_pkg::CLS_ZERO;
      end else if (ch == isp_pkg::CH_LO_X || ch == isp_pkg::CH_UP_X) begin
         token.cls = isp_pkg::CLS_X;
      end else begin
         token.cls = isp_pkg::CLS_OTHER;
      end

      priority if (ch >= isp_pkg::CH_ZERO && ch <= isp_pkg::CH_NINE) begin
         token.is_digit = 1'b1;
         token.digit    = isp_pkg::DIGIT_WIDTH'(ch - isp_pkg::CH_ZERO);
      end else if (ch >= isp_pkg::CH_LO_A && ch <= isp_pkg::CH_LO_F) begin
         token.is_digit = 1'b1;
         token.digit    = isp_pkg::DIGIT_WIDTH'(ch - isp_pkg::CH_LO_A + 8'd10);
      end else if (ch >= isp_pkg::CH_UP_A && ch <= isp_pkg::CH_UP_F) begin
         token.is_digit = 1'b1;
         token.digit    = isp_pkg::DIGIT_WIDTH'(ch - isp_pkg::CH_UP_A + 8'd10);
      end else begin
         token.is_digit = 1'b0;
         token.digit    = '0;
      end
   end

endmodule

// File: design/isp_queue.sv
module isp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  isp_pkg::token_type push_token,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output isp_pkg::token_type head
);

   localparam int DEPTH = 2;

   isp_pkg::token_type      slot_ff [DEPTH];
   logic                    wr_ptr_ff;
   logic                    wr_ptr_in;
   logic                    rd_ptr_ff;
   logic                    rd_ptr_in;
   logic [1:0]              count_ff;
   logic [1:0]              count_in;

   assign full      = (count_ff == 2'(DEPTH));
   assign not_empty = (count_ff != 2'd0);
   assign head      = slot_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;

   always_comb begin
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_token;
      end
   end

endmodule

// File: design/isp_back.sv
module isp_back #(
   parameter int VALUE_BITS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               tok_valid,
   input  isp_pkg::token_type tok,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output isp_pkg::rsp_type   rsp_payload
);

   localparam int BW = isp_pkg::BASE_WIDTH;
   localparam int CW = isp_pkg::CONSUMED_WIDTH;

   localparam logic [2:0] PH_DONE   = 3'd0;
   localparam logic [2:0] PH_LEAD   = 3'd1;
   localparam logic [2:0] PH_PREFIX = 3'd2;
   localparam logic [2:0] PH_ZERO   = 3'd3;
   localparam logic [2:0] PH_DIGITS = 3'd4;

   logic [2:0]            phase_ff, phase_in, cur_phase;
   logic [VALUE_BITS-1:0] accum_ff, accum_in, cur_accum;
   logic                  neg_ff, neg_in, cur_neg;
   logic [BW-1:0]         base_ff, base_in, cur_base;
   logic [CW-1:0]         count_ff, count_in, cur_count, count_inc;

   logic                  take_prefix;
   logic                  do_digit;
   logic                  emit;
   logic [BW-1:0]         dbase;
   logic [VALUE_BITS+BW-1:0] product;
   logic [VALUE_BITS-1:0] mac;
   logic signed [VALUE_BITS-1:0] final_value;

   logic                  rsp_valid_ff, rsp_valid_in;
   isp_pkg::rsp_type      rsp_ff;

   // a start mark restarts the parse on this very token
   assign cur_phase = tok.start ? PH_LEAD          : phase_ff;
   assign cur_accum = tok.start ? '0               : accum_ff;
   assign cur_neg   = tok.start ? 1'b0             : neg_ff;
   assign cur_base  = tok.start ? tok.base         : base_ff;
   assign cur_count = tok.start ? '0               : count_ff;

   assign count_inc = (cur_count == {CW{1'b1}}) ? cur_count : cur_count + 1'b1;

   assign product = {{BW{1'b0}}, cur_accum} * {{VALUE_BITS{1'b0}}, dbase};
   assign mac     = product[VALUE_BITS-1:0]
                    + {{(VALUE_BITS-isp_pkg::DIGIT_WIDTH){1'b0}}, tok.digit};

   assign final_value = cur_neg ? -cur_accum : cur_accum;

   always_comb begin
      phase_in    = cur_phase;
      accum_in    = cur_accum;
      neg_in      = cur_neg;
      base_in     = cur_base;
      count_in    = cur_count;
      take_prefix = 1'b0;
      do_digit    = 1'b0;
      dbase       = cur_base;
      emit        = 1'b0;

      unique case (cur_phase)
         PH_LEAD: begin
            if (tok.cls == isp_pkg::CLS_SPACE) begin
               count_in = count_inc;
            end else if (tok.cls == isp_pkg::CLS_PLUS || tok.cls == isp_pkg::CLS_MINUS) begin
               neg_in   = (tok.cls == isp_pkg::CLS_MINUS);
               count_in = count_inc;
               phase_in = PH_PREFIX;
            end else begin
               take_prefix = 1'b1;
            end
         end
         PH_PREFIX: take_prefix = 1'b1;
         PH_ZERO: begin
            if (tok.cls == isp_pkg::CLS_X) begin
               base_in  = isp_pkg::BASE_HEX;
               count_in = count_inc;
               phase_in = PH_DIGITS;
            end else begin
               base_in  = isp_pkg::BASE_OCT;
               dbase    = isp_pkg::BASE_OCT;
               do_digit = 1'b1;
            end
         end
         PH_DIGITS: do_digit = 1'b1;
         default: ;
      endcase

      if (take_prefix) begin
         if (cur_base == isp_pkg::BASE_AUTO) begin
            if (tok.cls == isp_pkg::CLS_ZERO) begin
               count_in = count_inc;
               phase_in = PH_ZERO;
            end else begin
               base_in  = isp_pkg::BASE_DEC;
               dbase    = isp_pkg::BASE_DEC;
               do_digit = 1'b1;
            end
         end else begin
            do_digit = 1'b1;
         end
      end

      if (do_digit) begin
         if (!tok.is_digit || {1'b0, tok.digit} >= dbase) begin
            emit     = 1'b1;
            phase_in = PH_DONE;
         end else begin
            accum_in = mac;
            count_in = count_inc;
            phase_in = PH_DIGITS;
         end
      end
   end

   // take a token only when the output slot is free or draining
   assign pop = tok_valid && (!rsp_valid_ff || rsp_ready);

   assign rsp_valid_in = pop ? emit : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_DONE;
         accum_ff     <= '0;
         neg_ff       <= 1'b0;
         base_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            phase_ff <= phase_in;
            accum_ff <= accum_in;
            neg_ff   <= neg_in;
            base_ff  <= base_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         rsp_ff.value    <= isp_pkg::OUT_WIDTH'(final_value);
         rsp_ff.consumed <= cur_count;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// File: design/integer_string_parser.sv
// Channel   Ports                               Direction  Carries
// request   req_valid req_ready req_payload     in         one character, start mark
// response  rsp_valid rsp_ready rsp_payload     out        value, characters consumed
// csr       csr_we csr_wdata                    in         number_base, no read-back
//
// One character a cycle is sustained while responses are taken; a result is registered
// in the output register as the back end takes its ending character from the queue.
// The multiply-add of the digit loop by the active base is combinational.
// Reset is synchronous, active high; afterwards the parser waits for a start mark.
// A stalled response holds the back end only; the two-entry queue keeps taking
// requests until it fills.
module integer_string_parser #(
   parameter int VALUE_BITS = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  isp_pkg::req_type               req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output isp_pkg::rsp_type               rsp_payload,
   input  logic                           csr_we,
   input  logic [isp_pkg::BASE_WIDTH-1:0] csr_wdata
);

   logic               q_push;
   logic               q_full;
   logic               q_pop;
   logic               q_valid;
   isp_pkg::token_type q_in_token;
   isp_pkg::token_type q_head;

   // classify each request and hold the radix register
   isp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .push        (q_push),
      .token       (q_in_token),
      .queue_full  (q_full)
   );

   // decouple the front from back-end stalls
   isp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_token (q_in_token),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_valid),
      .head       (q_head)
   );

   // advance the parse state and register results
   isp_back #(
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .tok_valid   (q_valid),
      .tok         (q_head),
      .pop         (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

`ifndef ASSERT_OFF
   // a stalled response must not be overwritten by a fresh token
   a_no_pop_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !q_pop)
      else $error("token taken while response stalled");

   // the back end never takes from an empty queue
   a_pop_needs_token: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty queue");

   // an accepted request is waiting in the queue on the next cycle
   a_request_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> q_valid)
      else $error("accepted request lost");

   // no response in the cycle after a reset edge
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");
`endif

endmodule
